### design/length_prefixed_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_defines.svh
// Assertion macros used by the deframer checker, lpfd_checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and codes of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int HEADER_BYTES_DEF = 4;
	localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_SHORT   = 2'd2;
	localparam logic [1:0] KIND_LONG    = 2'd3;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [15:0] message_type;
		logic        is_last;
		logic [1:0]  result_kind;
	} result_t;

endpackage

### design/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module lpfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] data_s1
);

	// Free slot, or the held byte leaves this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

endmodule

### design/lpfd_parser.sv
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame state, length register and per-byte result decode.
// ----------------------------------------------------------------------------
module lpfd_parser #(
	parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data,
	input  logic              valid_s1,
	input  logic [7:0]        data_s1,
	input  logic              advance,
	output logic              res_has,
	output lpfd_pkg::result_t res
);
	import lpfd_pkg::*;

	localparam logic [1:0]  PH_HEADER  = 2'd0;
	localparam logic [1:0]  PH_PAYLOAD = 2'd1;
	localparam logic [16:0] HdrLen     = 17'(HEADER_BYTES);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] len_q, len_d;
	logic [15:0] type_q, type_d;
	logic [15:0] max_len_q;
	logic [16:0] pos_inc;

	assign pos_inc = {1'b0, pos_q} + 17'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		type_d  = type_q;
		res_has = 1'b0;
		res     = '{payload_byte: 8'd0, message_type: type_q, is_last: 1'b1,
			result_kind: KIND_PAYLOAD};

		if (phase_q == PH_PAYLOAD) begin
			res_has          = 1'b1;
			res.payload_byte = data_s1;
			res.is_last      = pos_inc >= {1'b0, len_q};
			if (res.is_last) begin
				phase_d = PH_HEADER;
				pos_d   = 16'd0;
			end else begin
				pos_d = pos_inc[15:0];
			end
		end else begin
			// unused phase codes fall back to header parsing
			phase_d = PH_HEADER;
			if (pos_q == 16'd0) len_d[15:8]  = data_s1;
			if (pos_q == 16'd1) len_d[7:0]   = data_s1;
			if (pos_q == 16'd2) type_d[15:8] = data_s1;
			if (pos_q == 16'd3) type_d[7:0]  = data_s1;
			res.message_type = type_d;

			if (pos_inc < HdrLen) begin
				pos_d = pos_inc[15:0];
			end else begin
				pos_d = 16'd0;
				priority if ({1'b0, len_d} < HdrLen) begin
					res_has         = 1'b1;
					res.result_kind = KIND_SHORT;
				end else if (len_d > max_len_q) begin
					res_has         = 1'b1;
					res.result_kind = KIND_LONG;
				end else if ({1'b0, len_d} == HdrLen) begin
					res_has         = 1'b1;
					res.result_kind = KIND_EMPTY;
				end else begin
					phase_d = PH_PAYLOAD;
					pos_d   = HdrLen[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 16'd0;
			len_q   <= 16'd0;
			type_q  <= 16'd0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			type_q  <= type_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

endmodule

### design/lpfd_out_stage.sv
// ----------------------------------------------------------------------------
// lpfd_out_stage
// Result register toward the downstream channel.
// ----------------------------------------------------------------------------
module lpfd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lpfd_pkg::result_t res,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output lpfd_pkg::result_t res_q
);
	import lpfd_pkg::*;

	assign can_take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_take) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_take) begin
			res_q <= res;
		end
	end

endmodule

### design/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte stream to per-payload-byte results.
// Input register, then result register, to out_valid; one byte per cycle unless out_ready stalls the result register.
// Rate set by one input register and one result register, no internal loop.
// arst_n clears state; the length limit max_len_q returns to 65535.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer #(
	parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic [15:0] message_type,
	output logic        is_last,
	output logic [1:0]  result_kind
);
	import lpfd_pkg::*;

	logic    valid_s1;
	logic [7:0] data_s1;
	logic    advance;
	logic    res_has;
	logic    can_take;
	result_t res;
	result_t res_q;

	// byte leaves the input register unless its result has nowhere to go
	assign advance = valid_s1 && (!res_has || can_take);

	lpfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	lpfd_parser #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.advance    (advance),
		.res_has    (res_has),
		.res        (res)
	);

	lpfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1 && res_has),
		.res      (res),
		.can_take (can_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_q    (res_q)
	);

	assign payload_byte = res_q.payload_byte;
	assign message_type = res_q.message_type;
	assign is_last      = res_q.is_last;
	assign result_kind  = res_q.result_kind;

endmodule

### design/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  payload_byte,
	input logic [15:0] message_type,
	input logic        is_last,
	input logic [1:0]  result_kind
);
	import lpfd_pkg::*;

	`LPFD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(data_byte), "waiting input transaction changed")

	`LPFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(payload_byte) && $stable(message_type) && $stable(is_last)
		&& $stable(result_kind), "stalled result changed")

	`LPFD_ASSERT_NOW(a_nonpayload_last, out_valid && result_kind != KIND_PAYLOAD,
		is_last, "empty or error result without is_last")

	`LPFD_ASSERT_NOW(a_nonpayload_zero, out_valid && result_kind != KIND_PAYLOAD,
		payload_byte == 8'd0, "non-payload result carries a data byte")

	`LPFD_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready,
		"input stalled with an empty result register")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);
